### hdl/ssm_pkg.sv
// ssm_pkg: shared constants, register codes and types for substring_first_match
// depends on nothing; imported by every module of the block

package ssm_pkg;

	localparam int NEEDLE_MAX = 32;
	localparam int HAY_MAX    = 65536;
	localparam int REG_BYTES  = 32;
	localparam int CFG_WORDS  = 4;
	localparam int DATA_W     = 64;
	localparam int LEN_W      = 6;
	localparam int IDX_W      = 3;
	localparam int POS_W      = 16;
	localparam int OFS_W      = 7;
	localparam int SEEN_W     = $clog2(HAY_MAX + 2);
	localparam int WORD_SEL_W = $clog2(CFG_WORDS);

	typedef logic [7:0] byte_t;

	typedef enum logic [IDX_W-1:0] {
		REG_NEEDLE_LENGTH = 3'd0,
		REG_NEEDLE_WORD0  = 3'd1,
		REG_NEEDLE_WORD1  = 3'd2,
		REG_NEEDLE_WORD2  = 3'd3,
		REG_NEEDLE_WORD3  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             len_zero;
		logic             len_ok;
	} needle_ctl_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic             too_long;
	} result_t;

endpackage

### hdl/ssm_cell.sv
// ssm_cell: one window cell, holds one recent byte and its fill bit
// compares the byte it loads with its needle byte; uses ssm_pkg

module ssm_cell
	import ssm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift_en,
	input  logic  clear,
	input  byte_t d_byte,
	input  logic  d_fill,
	input  byte_t ref_byte,
	input  logic  in_use,
	output byte_t byte_q,
	output logic  fill_q,
	output logic  hit
);

	// term of the window compare for the window after this shift
	assign hit = !in_use || (d_fill && (d_byte == ref_byte));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 1'b0;
		end else if (clear) begin
			fill_q <= 1'b0;
		end else if (shift_en) begin
			fill_q <= d_fill;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= d_byte;
		end
	end

endmodule

### hdl/ssm_needle.sv
// ssm_needle: configuration registers and the needle aligned to the window cells
// uses ssm_pkg

module ssm_needle
	import ssm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [IDX_W-1:0]       cfg_index,
	input  logic [DATA_W-1:0]      cfg_data,
	output byte_t [NEEDLE_MAX-1:0] aligned_q,
	output logic [NEEDLE_MAX-1:0]  mask_q,
	output needle_ctl_t            ctl_q
);

	logic [LEN_W-1:0]  len_q;
	logic [DATA_W-1:0] word_q [CFG_WORDS];

	byte_t [NEEDLE_MAX-1:0] aligned_d;
	logic [NEEDLE_MAX-1:0]  mask_d;
	needle_ctl_t            ctl_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			for (int w = 0; w < CFG_WORDS; w++) begin
				word_q[w] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_NEEDLE_LENGTH: len_q <= cfg_data[LEN_W-1:0];
				REG_NEEDLE_WORD0:  word_q[0] <= cfg_data;
				REG_NEEDLE_WORD1:  word_q[1] <= cfg_data;
				REG_NEEDLE_WORD2:  word_q[2] <= cfg_data;
				REG_NEEDLE_WORD3:  word_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// cell j compares against needle byte len-1-j
	always_comb begin
		logic [OFS_W-1:0] k;
		k = '0;
		for (int j = 0; j < NEEDLE_MAX; j++) begin
			k = OFS_W'(len_q) - OFS_W'(1) - OFS_W'(j);
			mask_d[j] = OFS_W'(j) < OFS_W'(len_q);
			if (k < OFS_W'(REG_BYTES)) begin
				aligned_d[j] = word_q[k[WORD_SEL_W+2:3]][k[2:0]*8 +: 8];
			end else begin
				aligned_d[j] = '0;
			end
		end
		ctl_d.len      = len_q;
		ctl_d.len_zero = (len_q == '0);
		ctl_d.len_ok   = (len_q != '0) && (OFS_W'(len_q) <= OFS_W'(NEEDLE_MAX));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aligned_q <= '0;
			mask_q    <= '0;
			// empty needle
			ctl_q     <= '{len: '0, len_zero: 1'b1, len_ok: 1'b0};
		end else begin
			aligned_q <= aligned_d;
			mask_q    <= mask_d;
			ctl_q     <= ctl_d;
		end
	end

endmodule

### hdl/substring_first_match.sv
// substring_first_match: streaming first-occurrence search over a row of window cells
// depends on ssm_pkg, ssm_needle and ssm_cell
// a result is registered in the output register, or in the skid entry while the output stalls, when its byte is taken
// throughput: one byte per cycle while in_ready is high; a two-entry output (register plus skid) absorbs stalls
// in the cycle after a configuration write no byte is taken while the aligned needle updates
// reset: asynchronous, clears configuration, window fill bits, byte count, result flag and output valid flags

module substring_first_match
	import ssm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [DATA_W-1:0]  cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         haystack_byte,
	input  logic               last_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic [POS_W-1:0]   position,
	output logic               too_long
);

	localparam logic [SEEN_W-1:0] SEEN_LIMIT = SEEN_W'(HAY_MAX);

	byte_t [NEEDLE_MAX-1:0] aligned;
	logic [NEEDLE_MAX-1:0]  mask;
	needle_ctl_t            ctl;

	byte_t [NEEDLE_MAX-1:0] cell_byte;
	logic [NEEDLE_MAX-1:0]  cell_fill;
	logic [NEEDLE_MAX-1:0]  cell_hit;

	logic              cfg_busy_q;
	logic              result_given_q;
	logic [SEEN_W-1:0] seen_q;
	logic [SEEN_W-1:0] seen_next;

	logic    in_fire;
	logic    active;
	logic    shift_en;
	logic    clear;
	logic    match;
	logic    res_valid;
	result_t res;

	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;

	assign cfg_ready = 1'b1;

	ssm_needle u_needle (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.aligned_q (aligned),
		.mask_q    (mask),
		.ctl_q     (ctl)
	);

	assign in_ready = !cfg_busy_q && !skid_valid_q;
	assign in_fire  = in_valid && in_ready;
	assign active   = in_fire && !result_given_q;
	assign shift_en = active;
	assign clear    = in_fire && last_byte;

	genvar g;
	generate
		for (g = 0; g < NEEDLE_MAX; g++) begin : g_cell
			if (g == 0) begin : g_head
				ssm_cell u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.shift_en (shift_en),
					.clear    (clear),
					.d_byte   (haystack_byte),
					.d_fill   (1'b1),
					.ref_byte (aligned[g]),
					.in_use   (mask[g]),
					.byte_q   (cell_byte[g]),
					.fill_q   (cell_fill[g]),
					.hit      (cell_hit[g])
				);
			end else begin : g_body
				ssm_cell u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.shift_en (shift_en),
					.clear    (clear),
					.d_byte   (cell_byte[g-1]),
					.d_fill   (cell_fill[g-1]),
					.ref_byte (aligned[g]),
					.in_use   (mask[g]),
					.byte_q   (cell_byte[g]),
					.fill_q   (cell_fill[g]),
					.hit      (cell_hit[g])
				);
			end
		end
	endgenerate

	assign seen_next = (seen_q <= SEEN_LIMIT) ? seen_q + SEEN_W'(1) : seen_q;
	assign match     = ctl.len_ok && (&cell_hit);

	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		priority if (seen_next > SEEN_LIMIT) begin
			res.too_long = 1'b1;
			res_valid    = 1'b1;
		end else if (ctl.len_zero) begin
			res.found = 1'b1;
			res_valid = 1'b1;
		end else if (match) begin
			res.found    = 1'b1;
			res.position = POS_W'(seen_next - SEEN_W'(ctl.len));
			res_valid    = 1'b1;
		end else if (last_byte) begin
			res_valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_busy_q     <= 1'b0;
			result_given_q <= 1'b0;
			seen_q         <= '0;
		end else begin
			cfg_busy_q <= cfg_valid && cfg_ready;
			if (clear) begin
				result_given_q <= 1'b0;
				seen_q         <= '0;
			end else if (active) begin
				seen_q <= seen_next;
				if (res_valid) begin
					result_given_q <= 1'b1;
				end
			end
		end
	end

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= active && res_valid;
			end
		end else if (active && res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else begin
				out_q <= res;
			end
		end else if (active && res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = out_q.found;
	assign position  = out_q.position;
	assign too_long  = out_q.too_long;

endmodule
